FILE: design/plti_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plti_pkg
// Shared constants and types for the piecewise-linear table interpolator.
// ----------------------------------------------------------------------------
package plti_pkg;

  localparam int TableDepth = 64;
  localparam int AW         = $clog2(TableDepth);
  localparam int CW         = AW + 1;
  localparam int DW         = 32;
  localparam int NumW       = 49;
  localparam int DenW       = 33;
  localparam int StepW      = 6;
  localparam logic [StepW-1:0] DivLast = StepW'(NumW - 1);

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ZERO_DX = 2'd1,
    ST_RANGE   = 2'd2
  } stat_t;

  typedef enum logic [1:0] {
    RD_PREV = 2'd0,
    RD_MID  = 2'd1,
    RD_HI   = 2'd2,
    RD_LO   = 2'd3
  } rd_sel_t;

  typedef struct packed {
    logic    latch_in;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_xy;
    logic    diff_load;
    logic    div_init;
    logic    div_step;
    logic    wr_s;
    logic    wr_s_zero;
    logic    bis_init;
    logic    bis_upd;
    logic    hi_cap;
    logic    lo_cap;
    logic    mul;
    logic    shift;
    logic    sum;
    logic    rs_set;
    stat_t   rs_val;
    logic    out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic kind;
    logic idx_bad;
    logic idx_zero;
    logic dx_zero;
    logic div_last;
    logic span_gt1;
    logic x_eq;
    logic out_free;
  } ctrl_sts_t;

endpackage

FILE: design/plti_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plti_ctrl
// Sequencer for table loads (slope division) and bisection queries.
// ----------------------------------------------------------------------------
module plti_ctrl
  import plti_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_DEC   = 14'b00000000000010,
    S_LPREV = 14'b00000000000100,
    S_LDIVI = 14'b00000000001000,
    S_LDIV  = 14'b00000000010000,
    S_LSAT  = 14'b00000000100000,
    S_QTEST = 14'b00000001000000,
    S_QCMP  = 14'b00000010000000,
    S_QHI   = 14'b00000100000000,
    S_QLO   = 14'b00001000000000,
    S_QMUL  = 14'b00010000000000,
    S_QSH   = 14'b00100000000000,
    S_QADD  = 14'b01000000000000,
    S_DONE  = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.rd_sel = RD_PREV;
    cmd.rs_val = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.kind) begin
          cmd.bis_init = 1'b1;
          state_nxt    = S_QTEST;
        end else if (sts.idx_bad) begin
          cmd.rs_set = 1'b1;
          cmd.rs_val = ST_RANGE;
          state_nxt  = S_DONE;
        end else if (sts.idx_zero) begin
          cmd.wr_xy = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PREV;
          state_nxt  = S_LPREV;
        end
      end
      S_LPREV: begin
        cmd.wr_xy     = 1'b1;
        cmd.diff_load = 1'b1;
        state_nxt     = S_LDIVI;
      end
      S_LDIVI: begin
        if (sts.dx_zero) begin
          cmd.wr_s      = 1'b1;
          cmd.wr_s_zero = 1'b1;
          cmd.rs_set    = 1'b1;
          cmd.rs_val    = ST_ZERO_DX;
          state_nxt     = S_DONE;
        end else begin
          cmd.div_init = 1'b1;
          state_nxt    = S_LDIV;
        end
      end
      S_LDIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_LSAT;
        end
      end
      S_LSAT: begin
        cmd.wr_s  = 1'b1;
        state_nxt = S_DONE;
      end
      S_QTEST: begin
        cmd.rd_en = 1'b1;
        if (sts.span_gt1) begin
          cmd.rd_sel = RD_MID;
          state_nxt  = S_QCMP;
        end else begin
          cmd.rd_sel = RD_HI;
          state_nxt  = S_QHI;
        end
      end
      S_QCMP: begin
        cmd.bis_upd = 1'b1;
        state_nxt   = S_QTEST;
      end
      S_QHI: begin
        cmd.hi_cap = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_LO;
        state_nxt  = S_QLO;
      end
      S_QLO: begin
        cmd.lo_cap = 1'b1;
        state_nxt  = S_QMUL;
      end
      S_QMUL: begin
        if (sts.x_eq) begin
          cmd.rs_set = 1'b1;
          cmd.rs_val = ST_ZERO_DX;
          state_nxt  = S_DONE;
        end else begin
          cmd.mul   = 1'b1;
          state_nxt = S_QSH;
        end
      end
      S_QSH: begin
        cmd.shift = 1'b1;
        state_nxt = S_QADD;
      end
      S_QADD: begin
        cmd.sum   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: design/plti_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plti_dp
// Point tables, bit-serial slope divider, bisection registers, multiply and
// saturation, and the output register.
// ----------------------------------------------------------------------------
module plti_dp
  import plti_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [CW-1:0]   cfg_wdata,
  input  logic [71:0]     in_tdata,
  input  logic            in_tuser,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [39:0]     out_tdata,
  input  ctrl_cmd_t       cmd,
  output ctrl_sts_t       sts
);

  logic [DW-1:0] x_mem [TableDepth];
  logic [DW-1:0] y_mem [TableDepth];
  logic [DW-1:0] s_mem [TableDepth];

  logic [CW-1:0]        pcnt_r;
  logic [CW-1:0]        n_used;
  logic                 kind_r;
  logic [AW-1:0]        idx_r;
  logic signed [DW-1:0] xin_r, yin_r;
  logic signed [DW-1:0] rx_r, ry_r, rs_r;
  logic [AW-1:0]        lo_r, hi_r;
  logic [AW-1:0]        mid;
  logic [CW-1:0]        mid_sum;
  logic [AW-1:0]        ra;
  logic signed [DenW-1:0] dx_r, dy_r;
  logic [NumW-1:0]      num_r;
  logic [DenW-1:0]      den_r;
  logic [DenW-1:0]      rem_r;
  logic                 neg_r;
  logic [StepW-1:0]     step_r;
  logic [DenW:0]        trial;
  logic [DenW-1:0]      dx_mag, dy_mag;
  logic [DW-1:0]        slope_sat;
  logic signed [DW-1:0] xhi_r, ylo_r, slo_r;
  logic signed [DenW-1:0] d_r;
  logic                 eq_r;
  logic signed [64:0]   p_r;
  logic signed [64:0]   p_adj;
  logic signed [48:0]   q_r;
  logic signed [49:0]   ysum;
  logic [DW-1:0]        yres_r;
  stat_t                st_r;
  logic [39:0]          out_r;
  logic                 ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcnt_r <= CW'(TableDepth);
    end else if (cfg_we) begin
      pcnt_r <= cfg_wdata;
    end
  end

  always_comb begin
    n_used = pcnt_r;
    if (pcnt_r < CW'(2)) n_used = CW'(2);
    if (pcnt_r > CW'(TableDepth)) n_used = CW'(TableDepth);
  end

  assign mid_sum = {1'b0, hi_r} + {1'b0, lo_r};
  assign mid     = mid_sum[CW-1:1];

  always_comb begin
    case (cmd.rd_sel)
      RD_PREV: ra = idx_r - AW'(1);
      RD_MID:  ra = mid;
      RD_HI:   ra = hi_r;
      default: ra = lo_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      kind_r <= in_tuser;
      idx_r  <= in_tdata[5:0];
      xin_r  <= in_tdata[37:6];
      yin_r  <= in_tdata[69:38];
    end
    if (cmd.rd_en) begin
      rx_r <= x_mem[ra];
      ry_r <= y_mem[ra];
      rs_r <= s_mem[ra];
    end
    if (cmd.wr_xy) begin
      x_mem[idx_r] <= xin_r;
      y_mem[idx_r] <= yin_r;
    end
    if (cmd.wr_s) begin
      s_mem[idx_r - AW'(1)] <= cmd.wr_s_zero ? '0 : slope_sat;
    end
  end

  // slope division: |dy| << 16 over |dx|, one quotient bit per cycle
  assign dx_mag = dx_r[DenW-1] ? DenW'(-dx_r) : DenW'(dx_r);
  assign dy_mag = dy_r[DenW-1] ? DenW'(-dy_r) : DenW'(dy_r);
  assign trial  = {rem_r, num_r[NumW-1]} - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (cmd.diff_load) begin
      dx_r <= DenW'(xin_r) - DenW'(rx_r);
      dy_r <= DenW'(yin_r) - DenW'(ry_r);
    end
    if (cmd.div_init) begin
      num_r  <= {dy_mag[NumW-17:0], 16'd0};
      den_r  <= dx_mag;
      rem_r  <= '0;
      neg_r  <= dx_r[DenW-1] ^ dy_r[DenW-1];
      step_r <= '0;
    end else if (cmd.div_step) begin
      step_r <= step_r + StepW'(1);
      if (!trial[DenW]) begin
        rem_r <= trial[DenW-1:0];
        num_r <= {num_r[NumW-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[DenW-2:0], num_r[NumW-1]};
        num_r <= {num_r[NumW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (!neg_r) begin
      slope_sat = (num_r > NumW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : num_r[DW-1:0];
    end else begin
      slope_sat = (num_r > NumW'(32'h8000_0000)) ? 32'h8000_0000 : (-num_r[DW-1:0]);
    end
  end

  // bisection and evaluation
  assign p_adj = p_r + (p_r[64] ? 65'sd65535 : 65'sd0);
  assign ysum  = 50'(ylo_r) + 50'(q_r);

  always_ff @(posedge clk) begin
    if (cmd.bis_init) begin
      lo_r <= '0;
      hi_r <= AW'(n_used - CW'(1));
    end else if (cmd.bis_upd) begin
      if (rx_r > xin_r) hi_r <= mid;
      else lo_r <= mid;
    end
    if (cmd.hi_cap) xhi_r <= rx_r;
    if (cmd.lo_cap) begin
      eq_r  <= (rx_r == xhi_r);
      d_r   <= DenW'(xin_r) - DenW'(rx_r);
      ylo_r <= ry_r;
      slo_r <= rs_r;
    end
    if (cmd.mul)   p_r <= 65'(slo_r) * 65'(d_r);
    if (cmd.shift) q_r <= p_adj[64:16];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      yres_r <= '0;
      st_r   <= ST_OK;
    end else begin
      if (cmd.sum) begin
        if (ysum > 50'sh7FFF_FFFF)       yres_r <= 32'h7FFF_FFFF;
        else if (ysum < -50'sh8000_0000) yres_r <= 32'h8000_0000;
        else                             yres_r <= ysum[DW-1:0];
      end
      if (cmd.rs_set) st_r <= cmd.rs_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.out_load) begin
      ov_r <= 1'b1;
    end else if (out_tready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r <= {st_r, (kind_r ? lo_r : AW'(0)), yres_r};
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = out_r;

  assign sts.kind     = kind_r;
  assign sts.idx_bad  = ({1'b0, idx_r} >= n_used);
  assign sts.idx_zero = (idx_r == '0);
  assign sts.dx_zero  = (dx_r == '0);
  assign sts.div_last = (step_r == DivLast);
  assign sts.span_gt1 = ((hi_r - lo_r) > AW'(1));
  assign sts.x_eq     = eq_r;
  assign sts.out_free = !ov_r || out_tready;

endmodule

FILE: design/piecewise_linear_table_interp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_table_interp
// Q16.16 piecewise-linear interpolation over a 64-point table with bisection.
// ----------------------------------------------------------------------------
// One beat at a time. A load beat gets its slope from a restoring divider that
// yields one of 49 quotient bits per cycle. Index 0 and out-of-range loads
// skip the division, as does a load with zero x spacing. A query decodes,
// then runs one table read and one compare per bisection step (up to 6 steps
// for 64 points), then the end reads, the multiply, saturation and the result
// hand-off; a query on a zero-spacing segment skips the multiply and the sum.
// The result register lets the next beat start while a result waits on
// out_tready.
module piecewise_linear_table_interp
  import plti_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,   // point_count
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,    // point_index[5:0], x_value[37:6], y_value[69:38]
  input  logic        in_tuser,    // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata    // y_result[31:0], segment_low[37:32], status[39:38]
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  plti_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  plti_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
